[design/vid_code_to_millivolts_core_assert.svh]
// ----------------------------------------------------------------------------
// vid code to millivolts assertion macros
// shared assertion forms for the checker of the decoder core
// ----------------------------------------------------------------------------
`ifndef VID_CODE_TO_MILLIVOLTS_CORE_ASSERT_SVH
`define VID_CODE_TO_MILLIVOLTS_CORE_ASSERT_SVH

// clocked assertion, quiet while reset is high
`define VCMV_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("vcmv assertion failed");

// clocked assertion, also checked during reset
`define VCMV_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("vcmv assertion failed");

`endif

[design/vcmv_pkg.sv]
// ----------------------------------------------------------------------------
// vid code decoder package
// shared widths, version codes and stage payload types
// ----------------------------------------------------------------------------
package vcmv_pkg;

   localparam int CODE_W = 8;
   localparam int VER_W  = 8;
   localparam int MV_W   = 12;
   localparam int BASE_W = 13;
   localparam int STEP_W = 7;
   localparam int MULT_W = 8;
   localparam int SHF_W  = 2;
   localparam int PROD_W = 15;

   // version codes
   localparam logic [VER_W-1:0] VER_VRD10    = 8'd100;
   localparam logic [VER_W-1:0] VER_VRM11    = 8'd110;
   localparam logic [VER_W-1:0] VER_PIN5     = 8'd24;
   localparam logic [VER_W-1:0] VER_PIN6     = 8'd25;
   localparam logic [VER_W-1:0] VER_SERIAL7  = 8'd26;
   localparam logic [VER_W-1:0] VER_VRM90    = 8'd90;
   localparam logic [VER_W-1:0] VER_VRM91    = 8'd91;
   localparam logic [VER_W-1:0] VER_VRM85    = 8'd85;
   localparam logic [VER_W-1:0] VER_VRM84    = 8'd84;
   localparam logic [VER_W-1:0] VER_VRM82    = 8'd82;
   localparam logic [VER_W-1:0] VER_IMVP2    = 8'd17;
   localparam logic [VER_W-1:0] VER_BIT6     = 8'd13;
   localparam logic [VER_W-1:0] VER_BIT6_ALT = 8'd131;
   localparam logic [VER_W-1:0] VER_BIT7     = 8'd14;

   // result = (base - step * mult) >> shift
   typedef struct packed {
      logic [BASE_W-1:0] base;
      logic [STEP_W-1:0] step;
      logic [MULT_W-1:0] mult;
      logic [SHF_W-1:0]  shift;
   } term_type;

   typedef struct packed {
      logic [BASE_W-1:0] base;
      logic [PROD_W-1:0] prod;
      logic [SHF_W-1:0]  shift;
   } prod_type;

endpackage

[design/vcmv_decode.sv]
// ----------------------------------------------------------------------------
// vid code decoder, table stage
// maps version and code to a linear term: base, step, multiplier and shift
// ----------------------------------------------------------------------------
module vcmv_decode
   import vcmv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [CODE_W-1:0]     in_code,
   input  logic [VER_W-1:0]      in_version,
   output logic                  out_valid,
   input  logic                  out_ready,
   output term_type              out_term
);

   logic     valid_ff;
   logic     valid_in;
   term_type term_ff;
   term_type term_in;

   always_comb begin
      logic [4:0] c5;
      logic [3:0] c4;
      logic       b4;
      logic       b5;
      logic       rsvd;
      c5      = in_code[4:0];
      c4      = in_code[3:0];
      b4      = in_code[4];
      b5      = in_code[5];
      rsvd    = 1'b0;
      term_in = '{base: '0, step: '0, mult: '0, shift: '0};
      unique case (in_version)
         VER_VRD10: begin
            rsvd = (c5 == 5'h1f);
            if (c5 <= 5'h09 || in_code[5:0] == 6'h0a) begin
               term_in.base = b5 ? 13'd2151 : 13'd2176;
            end else begin
               term_in.base = b5 ? 13'd3701 : 13'd3726;
            end
            term_in.step  = 7'd50;
            term_in.mult  = {3'b0, c5};
            term_in.shift = 2'd1;
         end
         VER_VRM11: begin
            rsvd          = (in_code < 8'h02) || (in_code > 8'hb2);
            term_in.base  = 13'd6402;
            term_in.step  = 7'd25;
            term_in.mult  = in_code - 8'd2;
            term_in.shift = 2'd2;
         end
         VER_PIN5: begin
            rsvd         = (c5 == 5'h1f);
            term_in.base = 13'd1550;
            term_in.step = 7'd25;
            term_in.mult = {3'b0, c5};
         end
         VER_PIN6: begin
            term_in.step = 7'd25;
            if (!b5) begin
               term_in.base = 13'd1550;
               term_in.mult = {3'b0, c5};
            end else begin
               term_in.base  = 13'd1551;
               term_in.mult  = {2'b0, in_code[5:0]} - 8'd31;
               term_in.shift = 2'd1;
            end
         end
         VER_SERIAL7: begin
            rsvd          = (in_code[6:0] >= 7'h7c);
            term_in.base  = 13'd3101;
            term_in.step  = 7'd25;
            term_in.mult  = {1'b0, in_code[6:0]};
            term_in.shift = 2'd1;
         end
         VER_VRM90, VER_VRM91: begin
            rsvd         = (c5 == 5'h1f);
            term_in.base = 13'd1850;
            term_in.step = 7'd25;
            term_in.mult = {3'b0, c5};
         end
         VER_VRM85: begin
            if (c4 > 4'h4) begin
               term_in.base = b4 ? 13'd2075 : 13'd2050;
            end else begin
               term_in.base = b4 ? 13'd1275 : 13'd1250;
            end
            term_in.step = 7'd50;
            term_in.mult = {4'b0, c4};
         end
         VER_VRM84: begin
            term_in.base = 13'd2050;
            term_in.step = 7'd50;
            term_in.mult = {4'b0, c4};
         end
         VER_VRM82: begin
            rsvd         = (c5 == 5'h1f);
            term_in.base = b4 ? 13'd5100 : 13'd2050;
            term_in.step = b4 ? 7'd100 : 7'd50;
            term_in.mult = {3'b0, c5};
         end
         VER_IMVP2: begin
            term_in.base = b4 ? 13'd975 : 13'd1750;
            term_in.step = b4 ? 7'd25 : 7'd50;
            term_in.mult = {4'b0, c4};
         end
         VER_BIT6, VER_BIT6_ALT: begin
            term_in.base = 13'd1708;
            term_in.step = 7'd16;
            if (in_version == VER_BIT6_ALT && in_code[5:0] == 6'h3f) begin
               term_in.mult = 8'd64;
            end else begin
               term_in.mult = {2'b0, in_code[5:0]};
            end
         end
         VER_BIT7: begin
            rsvd          = (in_code[6:0] > 7'h77);
            term_in.base  = 13'd3001;
            term_in.step  = 7'd25;
            term_in.mult  = {1'b0, in_code[6:0]};
            term_in.shift = 2'd1;
         end
         default: begin
            rsvd = 1'b1;
         end
      endcase
      if (rsvd) begin
         term_in = '{base: '0, step: '0, mult: '0, shift: '0};
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         term_ff <= term_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_term  = term_ff;

endmodule

[design/vcmv_scale.sv]
// ----------------------------------------------------------------------------
// vid code decoder, multiply stage
// forms step times multiplier for the decoded term
// ----------------------------------------------------------------------------
module vcmv_scale
   import vcmv_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  term_type  in_term,
   output logic      out_valid,
   input  logic      out_ready,
   output prod_type  out_prod
);

   logic     valid_ff;
   logic     valid_in;
   prod_type prod_ff;
   prod_type prod_in;

   always_comb begin
      prod_in.base  = in_term.base;
      prod_in.prod  = PROD_W'(in_term.step) * PROD_W'(in_term.mult);
      prod_in.shift = in_term.shift;
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_prod  = prod_ff;

endmodule

[design/vcmv_finish.sv]
// ----------------------------------------------------------------------------
// vid code decoder, output stage
// subtracts the product from the base and applies the rounding shift
// ----------------------------------------------------------------------------
module vcmv_finish
   import vcmv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  prod_type         in_prod,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [MV_W-1:0]  out_mv
);

   logic              valid_ff;
   logic              valid_in;
   logic [MV_W-1:0]   mv_ff;
   logic [MV_W-1:0]   mv_in;
   logic [PROD_W-1:0] diff;

   assign diff  = PROD_W'(in_prod.base) - in_prod.prod;
   assign mv_in = MV_W'(diff >> in_prod.shift);

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         mv_ff <= mv_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_mv    = mv_ff;

endmodule

[design/vid_code_to_millivolts_core.sv]
// ----------------------------------------------------------------------------
// vid code to millivolts core
// Decodes a regulator voltage-identification code into the supply voltage
// in millivolts, using the table picked by the version register. The core
// takes one request per cycle unless the result side stalls, through a
// three-stage pipeline: table decode, a constant-step multiply, and a
// subtract with rounding shift. A result passes through the decode, multiply
// and finish registers before it is presented. Each stage holds its own valid
// bit, so back-pressure on the result side fills the pipeline without losing
// requests. Write the version only while no request is in flight.
// ----------------------------------------------------------------------------
module vid_code_to_millivolts_core
   import vcmv_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CODE_W-1:0]  req_vid_code,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [MV_W-1:0]    rsp_millivolts,
   input  logic               csr_wr_en,
   input  logic [VER_W-1:0]   csr_wr_data
);

   logic [VER_W-1:0] version_ff;
   logic [VER_W-1:0] version_in;
   logic             dec_valid;
   logic             dec_ready;
   term_type         dec_term;
   logic             scl_valid;
   logic             scl_ready;
   prod_type         scl_prod;

   assign version_in = csr_wr_en ? csr_wr_data : version_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= '0;
      end else begin
         version_ff <= version_in;
      end
   end

   vcmv_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_code    (req_vid_code),
      .in_version (version_ff),
      .out_valid  (dec_valid),
      .out_ready  (dec_ready),
      .out_term   (dec_term)
   );

   vcmv_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_term   (dec_term),
      .out_valid (scl_valid),
      .out_ready (scl_ready),
      .out_prod  (scl_prod)
   );

   vcmv_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (scl_valid),
      .in_ready  (scl_ready),
      .in_prod   (scl_prod),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_mv    (rsp_millivolts)
   );

endmodule

[design/vcmv_checker.sv]
// ----------------------------------------------------------------------------
// vid code decoder checker
// port-level checks on the decoder core, bound to the top level
// ----------------------------------------------------------------------------
`include "vid_code_to_millivolts_core_assert.svh"

module vcmv_checker
   import vcmv_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [CODE_W-1:0]  req_vid_code,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [MV_W-1:0]    rsp_millivolts
);

   logic [MV_W-1:0] mv_max;
   assign mv_max = 12'd3500;

   // no result straight out of reset
   `VCMV_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

   // a stalled result holds
   `VCMV_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_millivolts))

   // a waiting request holds
   `VCMV_ASSERT(a_req_hold, clock, reset,
      req_valid && !req_ready |=> req_valid && $stable(req_vid_code))

   // with the result side open, an accepted request comes out after passing the decode, multiply and finish registers
   `VCMV_ASSERT(a_latency, clock, reset,
      (req_valid && req_ready && rsp_ready) ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)

   // results stay within the decoder range
   `VCMV_ASSERT(a_mv_range, clock, reset, rsp_valid |-> rsp_millivolts <= mv_max)

endmodule

bind vid_code_to_millivolts_core vcmv_checker u_vcmv_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_vid_code   (req_vid_code),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_millivolts (rsp_millivolts)
);
